@@ src/mcd_pkg.sv @@
// Shared types and constants of the multi-click and drag detector.
// Depends on nothing; used by mcd_dist_sq and multi_click_drag_detector.
package mcd_pkg;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MOVE    = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_DOUBLE  = 3'd1,
    EV_TRIPLE  = 3'd2,
    EV_CLICK   = 3'd3,
    EV_RELEASE = 3'd4,
    EV_DRAG    = 3'd5
  } event_t;

  typedef enum logic {
    REG_DRAG_THRESHOLD = 1'b0,
    REG_CLICK_INTERVAL = 1'b1
  } cfg_reg_t;

  localparam int          CoordW       = 16;
  localparam int          DistW        = 2 * (CoordW + 1) + 1;
  localparam logic [1:0]  MaxCount     = 2'd3;
  localparam logic [7:0]  ThrReset     = 8'd4;
  localparam logic [15:0] IntervalReset = 16'd500;

endpackage

@@ src/mcd_dist_sq.sv @@
// Squared Euclidean distance between two signed 16-bit points.
// Depends on mcd_pkg for the coordinate and distance widths.
module mcd_dist_sq import mcd_pkg::*; (
  input  logic signed [CoordW-1:0] ax,
  input  logic signed [CoordW-1:0] ay,
  input  logic signed [CoordW-1:0] bx,
  input  logic signed [CoordW-1:0] by,
  output logic        [DistW-1:0]  sq_sum
);

  logic signed [CoordW:0]       dx;
  logic signed [CoordW:0]       dy;
  logic signed [2*CoordW+1:0]   dx2;
  logic signed [2*CoordW+1:0]   dy2;

  assign dx  = {ax[CoordW-1], ax} - {bx[CoordW-1], bx};
  assign dy  = {ay[CoordW-1], ay} - {by[CoordW-1], by};
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  // both squares are non-negative, so add them as unsigned magnitudes
  assign sq_sum = {1'b0, dx2} + {1'b0, dy2};

endmodule

@@ src/multi_click_drag_detector.sv @@
// Top level of the multi-click and drag detector: handshakes, state, classification.
// Depends on mcd_pkg and mcd_dist_sq.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | in_valid / in_ready       | opcode, button, pos_x, pos_y, time_ms
//  result   | out_valid / out_ready     | event_type, event_button
//  config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// One beat a cycle while the result side is not stalled. An input beat lands in the
// input register, is classified there against the per-button state, and the result
// register is loaded when the beat moves on. The combinational path is the two
// 17-bit squares of the distance unit plus the add and compare. Moves that report
// nothing clear out_valid and leave the result payload untouched. Reset (rst,
// synchronous) clears counts, held flags, drag flag and active button and loads the
// register defaults. A stalled result holds the input register and drops in_ready
// only when that register is also full.
module multi_click_drag_detector import mcd_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [1:0]               button,
  input  logic signed [CoordW-1:0] pos_x,
  input  logic signed [CoordW-1:0] pos_y,
  input  logic [31:0]              time_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               event_type,
  output logic [1:0]               event_button
);

  // the button field is two bits wide, so no more than four entries are reachable
  localparam int NB = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;
  localparam int IW = (NB > 1) ? $clog2(NB) : 1;

  // configuration
  logic [15:0] thr_sq;
  logic [15:0] click_interval;

  // input register
  logic                     ivalid;
  logic [1:0]               ireg_op;
  logic [1:0]               ireg_btn;
  logic signed [CoordW-1:0] ireg_x;
  logic signed [CoordW-1:0] ireg_y;
  logic [31:0]              ireg_time;

  // per-button and pointer state
  logic [1:0]               press_count [NB];
  logic [31:0]              last_time   [NB];
  logic signed [CoordW-1:0] last_x      [NB];
  logic signed [CoordW-1:0] last_y      [NB];
  logic                     held        [NB];
  logic                     drag_seen;
  logic signed [CoordW-1:0] anchor_x;
  logic signed [CoordW-1:0] anchor_y;
  logic [1:0]               active_btn;

  // classification
  logic             proceed;
  logic [IW-1:0]    bidx;
  logic [IW-1:0]    aidx;
  logic             btn_ok;
  logic             act_ok;
  logic [1:0]       cnt_cur;
  logic [1:0]       cnt_new;
  logic [31:0]      elapsed;
  logic             cont;
  logic             drag_fire;
  logic [DistW-1:0] press_dist;
  logic [DistW-1:0] move_dist;
  logic             res_valid;
  event_t           res_type;
  logic [1:0]       res_btn;

  // advance the input register whenever the result register is free or being drained
  assign proceed  = ivalid && (!out_valid || out_ready);
  assign in_ready = !ivalid || proceed;

  assign bidx   = ireg_btn[IW-1:0];
  assign aidx   = active_btn[IW-1:0];
  assign btn_ok = 32'(ireg_btn) < NUM_BUTTONS;
  assign act_ok = 32'(active_btn) < NUM_BUTTONS;

  mcd_dist_sq u_press_dist (
    .ax     (ireg_x),
    .ay     (ireg_y),
    .bx     (last_x[bidx]),
    .by     (last_y[bidx]),
    .sq_sum (press_dist)
  );

  mcd_dist_sq u_move_dist (
    .ax     (ireg_x),
    .ay     (ireg_y),
    .bx     (anchor_x),
    .by     (anchor_y),
    .sq_sum (move_dist)
  );

  always_comb begin
    cnt_cur   = press_count[bidx];
    elapsed   = ireg_time - last_time[bidx];
    // a run continues only inside the interval and within twice the drag distance
    cont      = (cnt_cur != 2'd0) && (elapsed <= {16'd0, click_interval}) &&
                (press_dist <= {{(DistW-18){1'b0}}, thr_sq, 2'b00});
    cnt_new   = (cont && cnt_cur != MaxCount) ? cnt_cur + 2'd1 : 2'd1;
    drag_fire = act_ok && held[aidx] && !drag_seen &&
                (move_dist > {{(DistW-16){1'b0}}, thr_sq});
    res_valid = 1'b0;
    res_type  = EV_PRESS;
    res_btn   = ireg_btn;
    unique case (opcode_t'(ireg_op))
      OP_PRESS: begin
        res_valid = btn_ok;
        if (cnt_new == 2'd2) begin
          res_type = EV_DOUBLE;
        end else if (cnt_new == MaxCount) begin
          res_type = EV_TRIPLE;
        end else begin
          res_type = EV_PRESS;
        end
      end
      OP_RELEASE: begin
        res_valid = btn_ok;
        res_type  = (!drag_seen && cnt_cur == 2'd1) ? EV_CLICK : EV_RELEASE;
      end
      OP_MOVE: begin
        res_valid = drag_fire;
        res_type  = EV_DRAG;
        res_btn   = active_btn;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // configuration writes; the squared threshold is kept instead of the raw distance
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq         <= 16'(ThrReset * ThrReset);
      click_interval <= IntervalReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRAG_THRESHOLD: thr_sq         <= 16'(cfg_data[7:0]) * 16'(cfg_data[7:0]);
        REG_CLICK_INTERVAL: click_interval <= cfg_data;
        default:            click_interval <= click_interval;
      endcase
    end
  end

  // input register: take a beat when empty or when the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ivalid <= 1'b1;
    end else if (proceed) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_op   <= opcode;
      ireg_btn  <= button;
      ireg_x    <= pos_x;
      ireg_y    <= pos_y;
      ireg_time <= time_ms;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB; i++) begin
        press_count[i] <= 2'd0;
        held[i]        <= 1'b0;
      end
      drag_seen  <= 1'b0;
      active_btn <= 2'd0;
    end else if (proceed) begin
      unique case (opcode_t'(ireg_op))
        OP_PRESS: begin
          if (btn_ok) begin
            held[bidx]        <= 1'b1;
            press_count[bidx] <= cnt_new;
            drag_seen         <= 1'b0;
            active_btn        <= ireg_btn;
          end
        end
        OP_RELEASE: begin
          if (btn_ok) begin
            held[bidx] <= 1'b0;
            drag_seen  <= 1'b0;
          end
        end
        OP_MOVE: begin
          // a drag ends any multi-click run of the active button
          if (drag_fire) begin
            drag_seen         <= 1'b1;
            press_count[aidx] <= 2'd0;
          end
        end
        default: begin
          drag_seen <= drag_seen;
        end
      endcase
    end
  end

  // payload state: only read once a press has written it
  always_ff @(posedge clk) begin
    if (proceed && opcode_t'(ireg_op) == OP_PRESS && btn_ok) begin
      last_time[bidx] <= ireg_time;
      last_x[bidx]    <= ireg_x;
      last_y[bidx]    <= ireg_y;
      anchor_x        <= ireg_x;
      anchor_y        <= ireg_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_valid) begin
      event_type   <= res_type;
      event_button <= res_btn;
    end
  end

  a_drag_clears_run: assert property (@(posedge clk) disable iff (rst)
    (proceed && opcode_t'(ireg_op) == OP_MOVE && drag_fire) |=>
      (drag_seen && press_count[$past(aidx)] == 2'd0))
    else $error("drag did not clear the run of the active button");

  a_press_sets_held: assert property (@(posedge clk) disable iff (rst)
    (proceed && opcode_t'(ireg_op) == OP_PRESS && btn_ok) |=>
      (held[$past(bidx)] && active_btn == $past(ireg_btn) && !drag_seen))
    else $error("press did not arm its button");

  a_button_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(event_button) < NUM_BUTTONS))
    else $error("result names a button beyond the configured count");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the result side was free");

endmodule
